// File: src/sjf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sjf_pkg: shared types and constants of the shortest-job-first scheduler
// Holds the controller state type, the command and status bundles that join
// the controller and the datapath, and the fixed field widths of the ports.
// ----------------------------------------------------------------------------
package sjf_pkg;

	// Fixed widths of the request and result fields.
	localparam int IN_TIME_W  = 16;
	localparam int IDX_W      = 4;
	localparam int OUT_TIME_W = 21;
	localparam int SUM_W      = 25;
	localparam int CNT_W      = 5;

	// Controller states.
	typedef enum logic [2:0] {
		ST_LOAD,
		ST_INIT,
		ST_SCAN,
		ST_DRAIN,
		ST_EMIT
	} sjf_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;    // store the accepted request
		logic init;    // restart the scan of the stored set
		logic issue;   // read the next stored entry
		logic commit;  // schedule the chosen job and register its result
		logic clear;   // return the set state to empty
	} sjf_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic issue_last;  // the entry being read is the last stored one
		logic out_free;    // the result register can take a new result
		logic final_pick;  // the next commit schedules the final job
	} sjf_sts_t;

endpackage

// File: src/sjf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sjf_ram: generic single-write, single-read RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module sjf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// File: src/sjf_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sjf_datapath: job store, selection scan and result register
// Stores the jobs of a set, scans them one entry per cycle to find the next
// job, keeps the schedule clock and wait sum, and holds the result register.
// ----------------------------------------------------------------------------
module sjf_datapath
	import sjf_pkg::*;
#(
	parameter int MAX_JOBS  = 16,
	parameter int TIME_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sjf_cmd_t              cmd,
	output sjf_sts_t              sts,
	input  logic [IN_TIME_W-1:0]  arrival_time,
	input  logic [IN_TIME_W-1:0]  burst_time,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [IDX_W-1:0]      job_index,
	output logic [OUT_TIME_W-1:0] start_time,
	output logic [OUT_TIME_W-1:0] completion_time,
	output logic [OUT_TIME_W-1:0] wait_time,
	output logic [SUM_W-1:0]      total_wait,
	output logic [CNT_W-1:0]      job_count,
	output logic                  last_result
);

	localparam int IW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
	localparam int CW = $clog2(MAX_JOBS + 1);
	localparam int TW = TIME_BITS + CW;
	localparam int EW = 2 * TIME_BITS;

	// Set state.
	logic [CW-1:0]    loaded_count_q;
	logic [CW-1:0]    sched_count_q;
	logic [TW-1:0]    cur_time_q;
	logic [SUM_W-1:0] wait_sum_q;
	logic             done_q [MAX_JOBS];

	// Scan state.
	logic [IW-1:0]        scan_idx_q;
	logic [IW-1:0]        idx_s1;
	logic                 vld_s1;
	logic                 found_q;
	logic [IW-1:0]        bi_q;
	logic [TIME_BITS-1:0] bb_q;
	logic [TIME_BITS-1:0] ba_q;
	logic                 efound_q;
	logic [IW-1:0]        ei_q;
	logic [TIME_BITS-1:0] eb_q;
	logic [TIME_BITS-1:0] ea_q;

	// Result register.
	logic                  out_valid_q;
	logic [IDX_W-1:0]      job_index_q;
	logic [OUT_TIME_W-1:0] start_time_q;
	logic [OUT_TIME_W-1:0] completion_time_q;
	logic [OUT_TIME_W-1:0] wait_time_q;
	logic [SUM_W-1:0]      total_wait_q;
	logic [CNT_W-1:0]      job_count_q;
	logic                  last_result_q;

	// Store write data, masked to the time width.
	logic [31:0]          arr_ext;
	logic [31:0]          bur_ext;
	logic [EW-1:0]        wdata;
	logic                 wr_en;
	logic [EW-1:0]        rdata;
	logic [TIME_BITS-1:0] rd_arr;
	logic [TIME_BITS-1:0] rd_bur;
	logic                 rd_done;
	logic                 rd_ready;
	logic                 rd_earlier;

	assign arr_ext = {16'b0, arrival_time};
	assign bur_ext = {16'b0, burst_time};
	assign wdata   = {bur_ext[TIME_BITS-1:0], arr_ext[TIME_BITS-1:0]};
	assign wr_en   = cmd.load && (loaded_count_q < CW'(MAX_JOBS));

	sjf_ram #(
		.WIDTH (EW),
		.DEPTH (MAX_JOBS),
		.AW    (IW)
	) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (loaded_count_q[IW-1:0]),
		.wdata (wdata),
		.raddr (scan_idx_q),
		.rdata (rdata)
	);

	// Compare the entry that returns from the store.
	always_comb begin
		rd_arr     = rdata[TIME_BITS-1:0];
		rd_bur     = rdata[EW-1:TIME_BITS];
		rd_done    = done_q[idx_s1];
		rd_ready   = !rd_done && (TW'(rd_arr) <= cur_time_q);
		rd_earlier = !rd_done && (!efound_q || (rd_arr < ea_q) ||
			((rd_arr == ea_q) && (rd_bur < eb_q)));
	end

	// Chosen job and its timing.
	logic [IW-1:0]        pick_idx;
	logic [TIME_BITS-1:0] pick_bur;
	logic [TIME_BITS-1:0] pick_arr;
	logic [TW-1:0]        start_w;
	logic [TW-1:0]        finish_w;
	logic [TW-1:0]        wait_w;
	logic [SUM_W-1:0]     sum_next;
	logic [63:0]          start64;
	logic [63:0]          finish64;
	logic [63:0]          wait64;
	logic [31:0]          idx32;
	logic [31:0]          cnt32;

	always_comb begin
		pick_idx = found_q ? bi_q : ei_q;
		pick_bur = found_q ? bb_q : eb_q;
		pick_arr = found_q ? ba_q : ea_q;
		start_w  = found_q ? cur_time_q : TW'(ea_q);
		finish_w = start_w + TW'(pick_bur);
		wait_w   = start_w - TW'(pick_arr);
		start64  = 64'(start_w);
		finish64 = 64'(finish_w);
		wait64   = 64'(wait_w);
		sum_next = wait_sum_q + wait64[SUM_W-1:0];
		idx32    = 32'(pick_idx);
		cnt32    = 32'(loaded_count_q);
	end

	assign sts.issue_last = (CW'(scan_idx_q) == (loaded_count_q - CW'(1)));
	assign sts.out_free   = !out_valid_q || !out_stall;
	assign sts.final_pick = (CW'(sched_count_q + CW'(1)) == loaded_count_q);

	// Set counters, schedule clock and wait sum.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_count_q <= '0;
			sched_count_q  <= '0;
			cur_time_q     <= '0;
			wait_sum_q     <= '0;
		end else if (cmd.clear) begin
			loaded_count_q <= '0;
			sched_count_q  <= '0;
			cur_time_q     <= '0;
			wait_sum_q     <= '0;
		end else begin
			if (wr_en) begin
				loaded_count_q <= loaded_count_q + CW'(1);
			end
			if (cmd.commit) begin
				sched_count_q <= sched_count_q + CW'(1);
				cur_time_q    <= finish_w;
				wait_sum_q    <= sum_next;
			end
		end
	end

	// Finished flags, one per stored job.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_JOBS; i++) begin
				done_q[i] <= 1'b0;
			end
		end else if (cmd.clear) begin
			for (int i = 0; i < MAX_JOBS; i++) begin
				done_q[i] <= 1'b0;
			end
		end else if (cmd.commit) begin
			done_q[pick_idx] <= 1'b1;
		end
	end

	// Scan address and read pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q <= '0;
			vld_s1     <= 1'b0;
		end else begin
			vld_s1 <= cmd.issue;
			if (cmd.init) begin
				scan_idx_q <= '0;
			end else if (cmd.issue) begin
				scan_idx_q <= scan_idx_q + IW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= scan_idx_q;
	end

	// Running best: shortest ready job, and earliest pending job.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q  <= 1'b0;
			efound_q <= 1'b0;
		end else if (cmd.init) begin
			found_q  <= 1'b0;
			efound_q <= 1'b0;
		end else if (vld_s1) begin
			if (rd_ready && (!found_q || (rd_bur < bb_q))) begin
				found_q <= 1'b1;
			end
			if (rd_earlier) begin
				efound_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			if (rd_ready && (!found_q || (rd_bur < bb_q))) begin
				bi_q <= idx_s1;
				bb_q <= rd_bur;
				ba_q <= rd_arr;
			end
			if (rd_earlier) begin
				ei_q <= idx_s1;
				eb_q <= rd_bur;
				ea_q <= rd_arr;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			job_index_q       <= idx32[IDX_W-1:0];
			start_time_q      <= start64[OUT_TIME_W-1:0];
			completion_time_q <= finish64[OUT_TIME_W-1:0];
			wait_time_q       <= wait64[OUT_TIME_W-1:0];
			total_wait_q      <= sts.final_pick ? sum_next : '0;
			job_count_q       <= sts.final_pick ? cnt32[CNT_W-1:0] : '0;
			last_result_q     <= sts.final_pick;
		end
	end

	assign out_valid       = out_valid_q;
	assign job_index       = job_index_q;
	assign start_time      = start_time_q;
	assign completion_time = completion_time_q;
	assign wait_time       = wait_time_q;
	assign total_wait      = total_wait_q;
	assign job_count       = job_count_q;
	assign last_result     = last_result_q;

	// A result is only registered when the previous one has gone.
	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> sts.out_free)
		else $error("result register overwritten");

	// Every commit has a pending job to schedule.
	a_commit_found: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (found_q || efound_q))
		else $error("commit without a pending job");

	// The schedule clock never runs backwards within a set.
	a_time_mono: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && !cmd.clear) |=> (cur_time_q >= $past(cur_time_q)))
		else $error("schedule clock went backwards");

	// The stored set never grows beyond the store.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		loaded_count_q <= CW'(MAX_JOBS))
		else $error("loaded count beyond store depth");

endmodule

// File: src/sjf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sjf_ctrl: scheduler controller
// Sequences loading, the per-choice scan of the store and the result commit.
// ----------------------------------------------------------------------------
module sjf_ctrl
	import sjf_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     last_job,
	output logic     in_stall,
	output sjf_cmd_t cmd,
	input  sjf_sts_t sts
);

	sjf_state_t state_q;
	sjf_state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (in_valid && last_job) begin
					state_d = ST_INIT;
				end
			end
			ST_INIT: begin
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (sts.issue_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					state_d = sts.final_pick ? ST_LOAD : ST_INIT;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	// Outputs.
	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_LOAD: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			ST_INIT: begin
				cmd.init = 1'b1;
			end
			ST_SCAN: begin
				cmd.issue = 1'b1;
			end
			ST_DRAIN: begin
				cmd = '0;
			end
			ST_EMIT: begin
				cmd.commit = sts.out_free;
				cmd.clear  = sts.out_free && sts.final_pick;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// Requests are only taken while loading.
	a_load_state: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (state_q == ST_LOAD))
		else $error("request stored outside loading");

endmodule

// File: src/nonpreemptive_sjf_scheduler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nonpreemptive_sjf_scheduler_top: non-preemptive shortest-job-first scheduler
// Loads a set of jobs, then emits one result per job in schedule order.
// ----------------------------------------------------------------------------
// Requests are taken while loading; the request marked last starts the run.
// Each result of an N-job set is found in order by setup, N reads through the
// single store read port, the last compare, and the commit.
// Results leave through a result register.
// The next set is taken while the final result still waits in the register.
// Reset clears the controller, counters and finished flags; the store is not.
// ----------------------------------------------------------------------------
module nonpreemptive_sjf_scheduler_top
	import sjf_pkg::*;
#(
	parameter int MAX_JOBS  = 16,
	parameter int TIME_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [IN_TIME_W-1:0]  arrival_time,
	input  logic [IN_TIME_W-1:0]  burst_time,
	input  logic                  last_job,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [IDX_W-1:0]      job_index,
	output logic [OUT_TIME_W-1:0] start_time,
	output logic [OUT_TIME_W-1:0] completion_time,
	output logic [OUT_TIME_W-1:0] wait_time,
	output logic [SUM_W-1:0]      total_wait,
	output logic [CNT_W-1:0]      job_count,
	output logic                  last_result
);

	sjf_cmd_t cmd;
	sjf_sts_t sts;

	// Controller.
	sjf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.last_job (last_job),
		.in_stall (in_stall),
		.cmd      (cmd),
		.sts      (sts)
	);

	// Datapath.
	sjf_datapath #(
		.MAX_JOBS  (MAX_JOBS),
		.TIME_BITS (TIME_BITS)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.arrival_time    (arrival_time),
		.burst_time      (burst_time),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.job_index       (job_index),
		.start_time      (start_time),
		.completion_time (completion_time),
		.wait_time       (wait_time),
		.total_wait      (total_wait),
		.job_count       (job_count),
		.last_result     (last_result)
	);

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the non-preemptive shortest-job-first scheduler
// Sends job sets over the request channel and predicts every schedule result
// in-house. Each result leaving the block is checked field by field against
// the oldest prediction. Both channels idle and stall at random, and a long
// receiver hold-off forces the block to stall its input.
// ----------------------------------------------------------------------------
module tb;
	import sjf_pkg::*;

	localparam int JOB_SLOTS     = 16;
	localparam int HOLD_CYCLES   = 400;
	localparam int QUIET_LIMIT   = 3000;
	localparam int SETTLE_CYCLES = 400;

	// One predicted schedule result.
	typedef struct packed {
		logic [IDX_W-1:0]      idx;
		logic [OUT_TIME_W-1:0] t_start;
		logic [OUT_TIME_W-1:0] t_done;
		logic [OUT_TIME_W-1:0] t_wait;
		logic [SUM_W-1:0]      sum_wait;
		logic [CNT_W-1:0]      count;
		logic                  is_last;
	} sched_res_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [IN_TIME_W-1:0]  arrival_time = '0;
	logic [IN_TIME_W-1:0]  burst_time = '0;
	logic                  last_job = 1'b0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [IDX_W-1:0]      job_index;
	logic [OUT_TIME_W-1:0] start_time;
	logic [OUT_TIME_W-1:0] completion_time;
	logic [OUT_TIME_W-1:0] wait_time;
	logic [SUM_W-1:0]      total_wait;
	logic [CNT_W-1:0]      job_count;
	logic                  last_result;

	// Predictor state: the job set being collected and the schedule clock.
	logic [IN_TIME_W-1:0] job_arr   [JOB_SLOTS];
	logic [IN_TIME_W-1:0] job_bur   [JOB_SLOTS];
	bit                   job_taken [JOB_SLOTS];
	int                   jobs_held;
	int                   jobs_done;
	longint unsigned      clock_now;
	longint unsigned      wait_acc;

	sched_res_t schedule_q[$];

	int  err_count    = 0;
	int  items_sent   = 0;
	int  results_seen = 0;
	int  sets_seen    = 0;
	int  idle_cycles  = 0;
	bit  gaps_on      = 1'b0;
	bit  stalls_on    = 1'b0;
	bit  hold_req     = 1'b0;
	int  hold_left    = 0;
	int  stall_left   = 0;

	nonpreemptive_sjf_scheduler_top u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.arrival_time    (arrival_time),
		.burst_time      (burst_time),
		.last_job        (last_job),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.job_index       (job_index),
		.start_time      (start_time),
		.completion_time (completion_time),
		.wait_time       (wait_time),
		.total_wait      (total_wait),
		.job_count       (job_count),
		.last_result     (last_result)
	);

	// Clock with a 12 ns period.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Prints one line per mismatch and counts it.
	task automatic report_error(input string msg);
		$display("[%0t] ERROR: %s", $time, msg);
		err_count++;
	endtask

	// Ready job with the smallest burst; the lowest index wins a tie.
	function automatic int pick_ready();
		int best;
		best = -1;
		for (int i = 0; i < jobs_held; i++) begin
			if (!job_taken[i] && job_arr[i] <= clock_now) begin
				if (best < 0 || job_bur[i] < job_bur[best]) begin
					best = i;
				end
			end
		end
		return best;
	endfunction

	// Stores an accepted job and, on the last one, predicts the whole schedule.
	function automatic void predict_schedule(input logic [IN_TIME_W-1:0] arr,
						 input logic [IN_TIME_W-1:0] bur,
						 input logic last);
		int              pick;
		int              n;
		bit              found;
		longint unsigned start_t;
		longint unsigned finish_t;
		longint unsigned wait_t;
		sched_res_t      r;
		if (jobs_held < JOB_SLOTS) begin
			job_arr[jobs_held] = arr;
			job_bur[jobs_held] = bur;
			jobs_held++;
		end
		if (!last) begin
			return;
		end
		n = jobs_held;
		while (jobs_done < n) begin
			pick = pick_ready();
			// Idle processor: jump to the earliest pending arrival.
			if (pick < 0) begin
				found = 1'b0;
				for (int i = 0; i < jobs_held; i++) begin
					if (!job_taken[i] && (!found || job_arr[i] < clock_now)) begin
						found     = 1'b1;
						clock_now = job_arr[i];
					end
				end
				pick = pick_ready();
			end
			start_t   = clock_now;
			finish_t  = start_t + job_bur[pick];
			wait_t    = finish_t - job_arr[pick] - job_bur[pick];
			clock_now = finish_t;
			job_taken[pick] = 1'b1;
			wait_acc += wait_t;
			jobs_done++;
			r.idx      = IDX_W'(pick);
			r.t_start  = OUT_TIME_W'(start_t);
			r.t_done   = OUT_TIME_W'(finish_t);
			r.t_wait   = OUT_TIME_W'(wait_t);
			r.is_last  = (jobs_done == n);
			r.sum_wait = r.is_last ? SUM_W'(wait_acc) : '0;
			r.count    = r.is_last ? CNT_W'(n) : '0;
			schedule_q.push_back(r);
		end
		// The set is finished: the block is ready for a new one.
		for (int i = 0; i < JOB_SLOTS; i++) begin
			job_taken[i] = 1'b0;
		end
		jobs_held = 0;
		jobs_done = 0;
		clock_now = 0;
		wait_acc  = 0;
	endfunction

	// Offers one job request, with an optional idle burst first, and waits
	// until it is accepted.
	task automatic send_job(input logic [IN_TIME_W-1:0] arr,
				input logic [IN_TIME_W-1:0] bur,
				input logic last);
		int gap;
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 14);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		arrival_time <= arr;
		burst_time   <= bur;
		last_job     <= last;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_schedule(arr, bur, last);
		items_sent++;
	endtask

	// Stops offering requests until every predicted result has arrived.
	task automatic drain();
		in_valid <= 1'b0;
		while (schedule_q.size() != 0) @(posedge clk);
	endtask

	// Result checking and receiver stall control.
	always @(posedge clk) begin
		sched_res_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (schedule_q.size() == 0) begin
					report_error($sformatf("unexpected result for job %0d", job_index));
				end else begin
					want = schedule_q.pop_front();
					if (job_index !== want.idx)
						report_error($sformatf("job_index got %0d expected %0d",
							job_index, want.idx));
					if (start_time !== want.t_start)
						report_error($sformatf("start_time got %0d expected %0d",
							start_time, want.t_start));
					if (completion_time !== want.t_done)
						report_error($sformatf("completion_time got %0d expected %0d",
							completion_time, want.t_done));
					if (wait_time !== want.t_wait)
						report_error($sformatf("wait_time got %0d expected %0d",
							wait_time, want.t_wait));
					if (total_wait !== want.sum_wait)
						report_error($sformatf("total_wait got %0d expected %0d",
							total_wait, want.sum_wait));
					if (job_count !== want.count)
						report_error($sformatf("job_count got %0d expected %0d",
							job_count, want.count));
					if (last_result !== want.is_last)
						report_error($sformatf("last_result got %0d expected %0d",
							last_result, want.is_last));
				end
				if (last_result === 1'b1) begin
					sets_seen++;
				end
			end
			// A requested hold-off takes priority over random stall bursts.
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES - 1;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (stalls_on && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 14) - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog: ends the run when nothing moves on either channel for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= QUIET_LIMIT) begin
					$display("Watchdog: no request or result accepted for %0d cycles",
						QUIET_LIMIT);
					$display("Verification failed");
					$finish;
				end
			end
		end
	end

	// One-job sets at both extremes; the late arrival leaves the processor idle.
	task automatic test_single_jobs();
		send_job(16'h0000, 16'h0000, 1'b1);
		send_job(16'hFFFF, 16'hFFFF, 1'b1);
	endtask

	// Equal bursts all ready at once: lowest index must be chosen first.
	task automatic test_tie_break();
		send_job(16'h0000, 16'h0005, 1'b0);
		send_job(16'h0000, 16'h0005, 1'b0);
		send_job(16'h0000, 16'h0005, 1'b1);
	endtask

	// Arrivals spread out so that time must jump over idle stretches.
	task automatic test_idle_processor();
		send_job(16'd100, 16'd3, 1'b0);
		send_job(16'd10, 16'd50, 1'b0);
		send_job(16'd500, 16'd1, 1'b1);
	endtask

	// A full set of extreme values, then a dropped request and a dropped
	// last request, which still starts the schedule of the stored set.
	task automatic test_full_set();
		logic [IN_TIME_W-1:0] arr;
		logic [IN_TIME_W-1:0] bur;
		for (int k = 0; k < JOB_SLOTS; k++) begin
			arr = k[0] ? 16'hFFFF : 16'h0000;
			bur = k[1] ? 16'hFFFF : IN_TIME_W'(k);
			send_job(arr, bur, 1'b0);
		end
		send_job(16'h1234, 16'h0001, 1'b0);
		send_job(16'h0000, 16'h0000, 1'b1);
	endtask

	// Receiver holds off for a long stretch while requests keep coming.
	task automatic test_backpressure();
		gaps_on  = 1'b0;
		hold_req = 1'b1;
		for (int s = 0; s < 3; s++) begin
			for (int k = 0; k < JOB_SLOTS; k++) begin
				send_job(IN_TIME_W'($urandom_range(0, 63)),
					 IN_TIME_W'($urandom_range(0, 31)), k == JOB_SLOTS - 1);
			end
		end
		gaps_on = 1'b1;
	endtask

	// Sender waits for the whole schedule before starting the next set.
	task automatic test_drain_pause();
		for (int k = 0; k < 5; k++) begin
			send_job(IN_TIME_W'($urandom_range(0, 200)),
				 IN_TIME_W'($urandom_range(0, 100)), k == 4);
		end
		drain();
		for (int k = 0; k < 3; k++) begin
			send_job(IN_TIME_W'($urandom()), IN_TIME_W'($urandom()), k == 2);
		end
		drain();
	endtask

	// Random sets of random size and value spread; a few overflow the store.
	task automatic test_random_sets(input int target);
		int                   first;
		int                   n_jobs;
		int                   mode;
		logic [IN_TIME_W-1:0] arr;
		logic [IN_TIME_W-1:0] bur;
		first = items_sent;
		while (items_sent - first < target) begin
			if (items_sent - first > target * 4 / 5) begin
				gaps_on   = 1'b0;
				stalls_on = 1'b0;
			end else begin
				gaps_on   = ($urandom_range(0, 3) != 0);
				stalls_on = ($urandom_range(0, 3) != 0);
			end
			if ($urandom_range(0, 9) == 0) begin
				n_jobs = $urandom_range(JOB_SLOTS + 1, JOB_SLOTS + 4);
			end else begin
				n_jobs = $urandom_range(1, JOB_SLOTS);
			end
			mode = $urandom_range(0, 3);
			for (int k = 0; k < n_jobs; k++) begin
				case (mode)
					0: begin
						arr = IN_TIME_W'($urandom_range(0, 31));
						bur = IN_TIME_W'($urandom_range(0, 15));
					end
					1: begin
						arr = IN_TIME_W'($urandom());
						bur = IN_TIME_W'($urandom());
					end
					2: begin
						arr = IN_TIME_W'($urandom());
						bur = IN_TIME_W'($urandom_range(0, 3));
					end
					default: begin
						arr = ($urandom_range(0, 2) == 0) ? 16'h0000 :
						      ($urandom_range(0, 1) == 0) ? 16'hFFFF :
						      IN_TIME_W'($urandom());
						bur = ($urandom_range(0, 2) == 0) ? 16'h0000 :
						      ($urandom_range(0, 1) == 0) ? 16'hFFFF :
						      IN_TIME_W'($urandom());
					end
				endcase
				send_job(arr, bur, k == n_jobs - 1);
			end
			if ($urandom_range(0, 7) == 0) begin
				drain();
			end
		end
	endtask

	// Test sequence.
	initial begin
		for (int i = 0; i < JOB_SLOTS; i++) begin
			job_taken[i] = 1'b0;
		end
		jobs_held = 0;
		jobs_done = 0;
		clock_now = 0;
		wait_acc  = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		gaps_on   = 1'b1;
		stalls_on = 1'b1;
		test_single_jobs();
		test_tie_break();
		test_idle_processor();
		test_full_set();
		test_backpressure();
		test_drain_pause();
		test_random_sets(320);
		// Let the last schedule finish, then allow for any stray result.
		gaps_on   = 1'b0;
		stalls_on = 1'b0;
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (schedule_q.size() != 0) begin
			report_error($sformatf("%0d predicted results never arrived",
				schedule_q.size()));
		end
		$display("Run covered %0d job requests in %0d completed sets, %0d results checked,",
			items_sent, sets_seen, results_seen);
		$display("with ties, idle gaps, store overflow and back-pressure on both channels.");
		if (err_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// File: files.f
src/sjf_pkg.sv
src/sjf_ram.sv
src/sjf_datapath.sv
src/sjf_ctrl.sv
src/nonpreemptive_sjf_scheduler_top.sv
tb/sv/tb.sv
